// File: hdl/ordered_list_store_macros.svh
// Assertion helpers for the ordered list store.
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define OLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_list_store: property violated");

// Next-cycle implication, disabled while reset is low.
`define OLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_list_store: property violated");

`endif

// File: hdl/ols_pkg.sv
package ols_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int NUM_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT     = 3'd1,
    OP_DELETE_AT  = 3'd2,
    OP_DELETE_VAL = 3'd3,
    OP_FIND       = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ols_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ols_stat_t;

endpackage

// File: hdl/ols_req_if.sv
interface ols_req_if import ols_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;
  logic                    remove_all;

  modport source (
    output valid, operation, position, item_value, remove_all,
    input  ready
  );

  modport sink (
    input  valid, operation, position, item_value, remove_all,
    output ready
  );
endinterface

// File: hdl/ols_rsp_if.sv
interface ols_rsp_if import ols_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    found_position;
  logic [NUM_W-1:0]    removed_count;
  logic [NUM_W-1:0]    entry_count;

  modport source (
    output valid, status, found_position, removed_count, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, found_position, removed_count, entry_count,
    output ready
  );
endinterface

// File: hdl/ordered_list_store.sv
// Ordered list store: a bounded list of up to CAPACITY signed 32-bit words.
// Requests arrive on req_i (valid/ready): operation, position, item_value,
// remove_all. Each request yields exactly one transaction on rsp_o
// (valid/ready): status, found_position, removed_count, entry_count.
// The list lives in a single-port-write, single-port-read memory with a
// registered read; a controller sweeps it one entry per cycle.
// Append, failed checks and unused codes need no sweep. Insert at p reads the
// entries from the last down to p and writes each one place up; delete at p
// reads the entries above p and writes each one place down; delete by value
// and find read every entry.
// One request is in flight at a time; req_i.ready is high only while idle.
// The result register sits between the sides: a request is accepted while an
// earlier result is still waiting, and that request only finishes once the
// receiver takes the waiting result. A stalled receiver holds rsp_o stable.
// Reset empties the list (internal count 0) and drops any pending result; the
// memory needs no clearing pass.
module ordered_list_store import ols_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ols_req_if.sink   req_i,
  ols_rsp_if.source rsp_o
);

  ols_cmd_t  cmd;
  ols_stat_t stat;

  ols_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ols_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .operation_i      (req_i.operation),
    .position_i       (req_i.position),
    .item_value_i     (req_i.item_value),
    .remove_all_i     (req_i.remove_all),
    .status_o         (rsp_o.status),
    .found_position_o (rsp_o.found_position),
    .removed_count_o  (rsp_o.removed_count),
    .entry_count_o    (rsp_o.entry_count)
  );

endmodule

// File: hdl/ols_ctrl.sv
module ols_ctrl import ols_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  ols_stat_t stat_i,
  output ols_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = (state_q == S_IDLE);
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done && out_free) begin
          cmd_o.commit = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

// File: hdl/ols_datapath.sv
module ols_datapath import ols_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ols_cmd_t                cmd_i,
  output ols_stat_t               stat_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] item_value_i,
  input  logic                    remove_all_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [POS_W-1:0]        found_position_o,
  output logic [NUM_W-1:0]        removed_count_o,
  output logic [NUM_W-1:0]        entry_count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  op_e              op_q, op_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             all_q, all_d;
  logic             ok_q, ok_d;
  status_e          status_q, status_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    left_q, left_d;
  logic [AW-1:0]    rp_q, rp_d;
  logic             rv_q, rv_d;
  logic [AW-1:0]    tag_q, tag_d;
  logic [CW-1:0]    keep_q, keep_d;
  logic [CW-1:0]    removed_q, removed_d;
  logic [AW-1:0]    found_q, found_d;
  logic             hit_q, hit_d;

  status_e          out_status_q, out_status_d;
  logic [POS_W-1:0] out_found_q, out_found_d;
  logic [NUM_W-1:0] out_removed_q, out_removed_d;
  logic [NUM_W-1:0] out_count_q, out_count_d;

  logic             issue;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             match;
  logic             full;
  logic [WW-1:0]    pos_w, cnt_w;
  status_e          status_c;
  logic [AW-1:0]    found_c;
  logic [CW-1:0]    removed_c;
  logic [CW-1:0]    count_c;

  assign issue  = cmd_i.scan && (left_q != '0);
  assign match  = (rdata_q == val_q);
  assign full   = (count_q == CW'(CAPACITY));
  assign pos_w  = WW'(position_i);
  assign cnt_w  = WW'(count_q);
  assign stat_o.scan_done = (left_q == '0) && !rv_q;

  always_comb begin
    op_d      = op_q;
    pos_d     = pos_q;
    val_d     = val_q;
    all_d     = all_q;
    ok_d      = ok_q;
    status_d  = status_q;
    count_d   = count_q;
    left_d    = left_q;
    rp_d      = rp_q;
    rv_d      = issue;
    tag_d     = rp_q;
    keep_d    = keep_q;
    removed_d = removed_q;
    found_d   = found_q;
    hit_d     = hit_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = rdata_q;
    status_c  = status_q;
    found_c   = '0;
    removed_c = '0;
    count_c   = count_q;
    out_status_d  = out_status_q;
    out_found_d   = out_found_q;
    out_removed_d = out_removed_q;
    out_count_d   = out_count_q;

    // latch the transaction and set up the memory sweep
    if (cmd_i.load) begin
      op_d      = op_e'(operation_i);
      pos_d     = position_i;
      val_d     = item_value_i;
      all_d     = remove_all_i;
      keep_d    = '0;
      removed_d = '0;
      found_d   = '0;
      hit_d     = 1'b0;
      ok_d      = 1'b0;
      status_d  = ST_OK;
      left_d    = '0;
      rp_d      = '0;
      unique case (op_e'(operation_i)) inside
        OP_APPEND: begin
          if (full) status_d = ST_FULL;
          else      ok_d     = 1'b1;
        end
        OP_INSERT: begin
          if (pos_w >= cnt_w) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            ok_d   = 1'b1;
            left_d = CW'(cnt_w - pos_w);
            rp_d   = AW'(count_q - CW'(1));
          end
        end
        OP_DELETE_AT: begin
          if (pos_w >= cnt_w) begin
            status_d = ST_RANGE;
          end else begin
            ok_d   = 1'b1;
            left_d = CW'(cnt_w - pos_w - WW'(1));
            rp_d   = AW'(pos_w + WW'(1));
          end
        end
        OP_DELETE_VAL, OP_FIND: begin
          ok_d   = 1'b1;
          left_d = count_q;
        end
        default: ok_d = 1'b0;
      endcase
    end

    // advance the read pointer
    if (issue) begin
      left_d = left_q - CW'(1);
      rp_d   = (op_q == OP_INSERT) ? rp_q - AW'(1) : rp_q + AW'(1);
    end

    // consume read data
    if (rv_q) begin
      unique case (op_q)
        OP_INSERT: begin
          we    = 1'b1;
          waddr = tag_q + AW'(1);
        end
        OP_DELETE_AT: begin
          we    = 1'b1;
          waddr = tag_q - AW'(1);
        end
        OP_DELETE_VAL: begin
          if (match && (all_q || (removed_q == '0))) begin
            removed_d = removed_q + CW'(1);
          end else begin
            we     = 1'b1;
            waddr  = AW'(keep_q);
            keep_d = keep_q + CW'(1);
          end
        end
        OP_FIND: begin
          if (match && !hit_q) begin
            hit_d   = 1'b1;
            found_d = tag_q;
          end
        end
        default: we = 1'b0;
      endcase
    end

    // finish the transaction and load the result register
    if (cmd_i.commit) begin
      unique case (op_q)
        OP_APPEND: begin
          if (ok_q) begin
            we      = 1'b1;
            waddr   = AW'(count_q);
            wdata   = val_q;
            count_c = count_q + CW'(1);
          end
        end
        OP_INSERT: begin
          if (ok_q) begin
            we      = 1'b1;
            waddr   = AW'(pos_q);
            wdata   = val_q;
            count_c = count_q + CW'(1);
          end
        end
        OP_DELETE_AT: begin
          if (ok_q) begin
            count_c   = count_q - CW'(1);
            removed_c = CW'(1);
          end
        end
        OP_DELETE_VAL: begin
          count_c   = keep_q;
          removed_c = removed_q;
          status_c  = (removed_q == '0) ? ST_NOT_FOUND : ST_OK;
        end
        OP_FIND: begin
          status_c = hit_q ? ST_OK : ST_NOT_FOUND;
          found_c  = hit_q ? found_q : '0;
        end
        default: status_c = ST_OK;
      endcase
      count_d       = count_c;
      out_status_d  = status_c;
      out_found_d   = POS_W'(found_c);
      out_removed_d = NUM_W'(removed_c);
      out_count_d   = NUM_W'(count_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    all_q         <= all_d;
    ok_q          <= ok_d;
    status_q      <= status_d;
    rp_q          <= rp_d;
    tag_q         <= tag_d;
    keep_q        <= keep_d;
    removed_q     <= removed_d;
    found_q       <= found_d;
    hit_q         <= hit_d;
    out_status_q  <= out_status_d;
    out_found_q   <= out_found_d;
    out_removed_q <= out_removed_d;
    out_count_q   <= out_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (issue) rdata_q <= mem_q[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
  end

  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign removed_count_o  = out_removed_q;
  assign entry_count_o    = out_count_q;

endmodule

// File: hdl/ols_checker.sv
`include "ordered_list_store_macros.svh"

module ols_checker import ols_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [POS_W-1:0]    found_position_i,
  input logic [NUM_W-1:0]    removed_count_i,
  input logic [NUM_W-1:0]    entry_count_i
);

  `OLS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `OLS_ASSERT_NEXT(a_single_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)
  `OLS_ASSERT_IMPLY(a_no_removal_on_error, clk_i, rst_ni, rsp_valid_i && (status_i != ST_OK), removed_count_i == '0)
  `OLS_ASSERT_IMPLY(a_found_only_ok, clk_i, rst_ni, rsp_valid_i && (found_position_i != '0), status_i == ST_OK)
  `OLS_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, rsp_valid_i, (CAPACITY > 127) || (int'(entry_count_i) <= CAPACITY))

endmodule

bind ordered_list_store ols_checker #(
  .CAPACITY (CAPACITY)
) u_ols_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .found_position_i (rsp_o.found_position),
  .removed_count_i  (rsp_o.removed_count),
  .entry_count_i    (rsp_o.entry_count)
);
